// File: hw/rtl/b64d_pkg.sv
// Shared types and constants for the base64 stream decoder.
// No dependencies; imported by b64d_char_class and base64_stream_decoder_unit.
package b64d_pkg;

    typedef enum logic [1:0] {
        MODE_RUNNING,
        MODE_PADDED,
        MODE_HALTED,
        MODE_ENDED
    } run_mode_t;

    typedef enum logic [2:0] {
        ST_DATA,
        ST_DONE,
        ST_BAD_GROUP,
        ST_BAD_CHAR,
        ST_TRUNCATED
    } status_t;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_PAD     = 8'h3d;
    localparam logic [7:0] CHAR_CR      = 8'h0d;
    localparam logic [7:0] CHAR_LF      = 8'h0a;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [7:0] LOWER_OFFSET = 8'd26;
    localparam logic [7:0] DIGIT_OFFSET = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef struct packed {
        logic       is_space;   // CR, LF, tab or space
        logic       is_alpha;   // alphabet character or pad
        logic       is_pad;
        logic [5:0] sextet;     // pad reads as zero
    } char_class_t;

endpackage

// File: hw/rtl/b64d_char_class.sv
// Character classifier: whitespace, alphabet, pad and 6-bit value.
// Depends on b64d_pkg.
module b64d_char_class (
    input  logic [7:0]            char_in,
    output b64d_pkg::char_class_t cls
);
    import b64d_pkg::*;

    logic       upper;
    logic       lower;
    logic       digit;
    logic       plus;
    logic       slash;
    logic [7:0] diff;

    assign upper = (char_in >= CHAR_UPPER_A) && (char_in <= CHAR_UPPER_Z);
    assign lower = (char_in >= CHAR_LOWER_A) && (char_in <= CHAR_LOWER_Z);
    assign digit = (char_in >= CHAR_DIGIT_0) && (char_in <= CHAR_DIGIT_9);
    assign plus  = (char_in == CHAR_PLUS);
    assign slash = (char_in == CHAR_SLASH);

    always_comb begin
        diff = 8'd0;
        if (upper) begin
            diff = char_in - CHAR_UPPER_A;
        end else if (lower) begin
            diff = char_in - CHAR_LOWER_A + LOWER_OFFSET;
        end else if (digit) begin
            diff = char_in - CHAR_DIGIT_0 + DIGIT_OFFSET;
        end
    end

    always_comb begin
        cls.is_space = (char_in == CHAR_CR) || (char_in == CHAR_LF) ||
                       (char_in == CHAR_TAB) || (char_in == CHAR_SPACE);
        cls.is_pad   = (char_in == CHAR_PAD);
        cls.is_alpha = upper || lower || digit || plus || slash || cls.is_pad;
        if (plus) begin
            cls.sextet = SEXTET_PLUS;
        end else if (slash) begin
            cls.sextet = SEXTET_SLASH;
        end else begin
            cls.sextet = diff[5:0];
        end
    end

endmodule

// File: hw/rtl/base64_stream_decoder_unit.sv
// Streaming base64 decoder top level: input register, group decode, result buffer.
// Depends on b64d_pkg and b64d_char_class.
//
// Accepts one character per clock on the s_ channel while s_tready is high; s_tlast
// marks end of input. Each character passes an input register and is then decoded
// into a result buffer of up to three results, which the m_ port sends one per cycle
// while m_tready is high. A character that yields no result leaves the input register
// without waiting for the buffer, even while earlier results are still being sent. A
// character that yields results waits in the input register until the buffer has
// sent its last result, so a group of two or three bytes holds the result port while
// the leading characters of the next group keep flowing; with m_tready held high the
// input sustains one character per cycle within a run of groups. m_tuser carries the
// status (0 data, 1 done, 2 bad group, 3 bad character, 4 truncated) and m_tlast
// flags the final result of an input character. After an error or end of input the
// block drops every character until reset. ignore_garbage is written through cfg_
// and should only change while idle.
module base64_stream_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [2:0] status
    output logic       m_tlast,   // last_of_run
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // ignore_garbage
);
    import b64d_pkg::*;

    logic        ignore_garbage_reg;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_eoi_reg;

    run_mode_t   mode_reg;
    run_mode_t   mode_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [5:0]  sx_reg  [3];
    logic        pad_reg [3];

    logic        grp_valid_reg;
    logic [7:0]  grp_byte_reg [3];
    status_t     grp_status_reg;
    logic [1:0]  grp_last_reg;
    logic [1:0]  idx_reg;

    char_class_t cls;
    logic        grp_free;
    logic        in_adv;
    logic        cand_live;
    logic        live;
    logic        take_char;
    logic        group_full;
    logic        bad_group;

    logic [1:0]  res_n;
    status_t     res_status;
    logic [7:0]  res_byte [3];
    logic [23:0] word;

    b64d_char_class u_class (
        .char_in (in_char_reg),
        .cls     (cls)
    );

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_garbage_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            ignore_garbage_reg <= cfg_data;
        end
    end

    // input register; a character without results need not wait for the buffer
    assign grp_free = !grp_valid_reg || (m_tready && (idx_reg == grp_last_reg));
    assign in_adv   = in_valid_reg && (grp_free || (res_n == 2'd0));
    assign s_tready = !in_valid_reg || in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (in_adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    // shared decode of the registered character
    assign cand_live  = in_valid_reg && ((mode_reg == MODE_RUNNING) ||
                                         (mode_reg == MODE_PADDED));
    assign live       = cand_live && in_adv;
    assign take_char  = live && !in_eoi_reg && (mode_reg == MODE_RUNNING) &&
                        !cls.is_space && cls.is_alpha;
    assign group_full = (count_reg == 2'd3);
    assign bad_group  = pad_reg[0] || pad_reg[1] || (pad_reg[2] && !cls.is_pad);
    assign word       = {sx_reg[0], sx_reg[1], sx_reg[2], cls.sextet};

    // next state
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (live) begin
            if (in_eoi_reg) begin
                mode_next = MODE_ENDED;
            end else if (mode_reg == MODE_RUNNING && !cls.is_space) begin
                if (!cls.is_alpha) begin
                    if (!ignore_garbage_reg) begin
                        mode_next = MODE_HALTED;
                    end
                end else if (!group_full) begin
                    count_next = count_reg + 2'd1;
                end else begin
                    count_next = 2'd0;
                    if (bad_group) begin
                        mode_next = MODE_HALTED;
                    end else if (cls.is_pad) begin
                        mode_next = MODE_PADDED;
                    end
                end
            end
        end
    end

    // results of the registered character
    always_comb begin
        res_n       = 2'd0;
        res_status  = ST_DATA;
        res_byte[0] = 8'd0;
        res_byte[1] = 8'd0;
        res_byte[2] = 8'd0;
        if (cand_live) begin
            if (in_eoi_reg) begin
                res_n      = 2'd1;
                res_status = (mode_reg == MODE_RUNNING && count_reg != 2'd0) ?
                             ST_TRUNCATED : ST_DONE;
            end else if (mode_reg == MODE_RUNNING && !cls.is_space) begin
                if (!cls.is_alpha) begin
                    if (!ignore_garbage_reg) begin
                        res_n      = 2'd1;
                        res_status = ST_BAD_CHAR;
                    end
                end else if (group_full) begin
                    if (bad_group) begin
                        res_n      = 2'd1;
                        res_status = ST_BAD_GROUP;
                    end else begin
                        res_byte[0] = word[23:16];
                        res_byte[1] = word[15:8];
                        res_byte[2] = word[7:0];
                        if (pad_reg[2]) begin
                            res_n = 2'd1;
                        end else if (cls.is_pad) begin
                            res_n = 2'd2;
                        end else begin
                            res_n = 2'd3;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_RUNNING;
            count_reg <= 2'd0;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    // group store, one slot per leading character of a group
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (take_char && (count_reg == 2'(i))) begin
                sx_reg[i]  <= cls.sextet;
                pad_reg[i] <= cls.is_pad;
            end
        end
    end

    // result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (grp_free) begin
            grp_valid_reg <= in_adv && (res_n != 2'd0);
            idx_reg       <= 2'd0;
        end else if (m_tready) begin
            idx_reg       <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && grp_free) begin
            grp_byte_reg[0] <= res_byte[0];
            grp_byte_reg[1] <= res_byte[1];
            grp_byte_reg[2] <= res_byte[2];
            grp_status_reg  <= res_status;
            grp_last_reg    <= res_n - 2'd1;
        end
    end

    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = (idx_reg == 2'd0) ? grp_byte_reg[0] :
                      (idx_reg == 2'd1) ? grp_byte_reg[1] : grp_byte_reg[2];
    assign m_tuser  = grp_status_reg;
    assign m_tlast  = (idx_reg == grp_last_reg);

`ifndef SYNTH
    // only data results come in runs longer than one
    a_status_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && grp_status_reg != ST_DATA) |-> (grp_last_reg == 2'd0))
        else $error("non-data result in a multi-result run");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg <= grp_last_reg))
        else $error("result index past end of run");

    a_stopped_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_HALTED || mode_reg == MODE_ENDED) |-> (res_n == 2'd0))
        else $error("result produced after halt or end");

    a_padded_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_PADDED) |-> (count_reg == 2'd0))
        else $error("partial group pending after padding");

    a_halt_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_HALTED && mode_next == MODE_HALTED) |=>
        (grp_valid_reg && (grp_status_reg == ST_BAD_GROUP ||
                           grp_status_reg == ST_BAD_CHAR)))
        else $error("halt without error result");
`endif

endmodule
